### hdl/uart_buffered_rx_tx_rings_unit_macros.svh
// ----------------------------------------------------------------------------
// UART ring buffer assertion macros
// Concurrent assertion helpers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UART_BUFFERED_RX_TX_RINGS_UNIT_MACROS_SVH
`define UART_BUFFERED_RX_TX_RINGS_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define URB_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("urb assertion failed");
// Next-cycle implication, disabled during reset
`define URB_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("urb assertion failed");
`else
`define URB_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define URB_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

### hdl/urb_pkg.sv
// ----------------------------------------------------------------------------
// urb_pkg
// Types, codes and sizes shared by the UART ring buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package urb_pkg;

  // Ring depths and derived widths
  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);
  localparam int TX_CW    = $clog2(TX_DEPTH + 1);

  // Size registers and count outputs
  localparam int SIZE_W   = 9;
  localparam int CNT_W    = 9;
  localparam int SIZE_RST = 256;
  localparam int RX_SZW   = (RX_CW > SIZE_W) ? RX_CW : SIZE_W;
  localparam int TX_SZW   = (TX_CW > SIZE_W) ? TX_CW : SIZE_W;
  localparam int RX_EFF_RST = (SIZE_RST > RX_DEPTH) ? RX_DEPTH : SIZE_RST;
  localparam int TX_EFF_RST = (SIZE_RST > TX_DEPTH) ? TX_DEPTH : SIZE_RST;

  // Configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 9;
  localparam logic [CFG_IW-1:0] REG_RX_SIZE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_TX_SIZE = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ENABLED = 2'd2;

  // Command queue
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Input modes
  localparam logic [2:0] MODE_LINE   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_READ   = 3'd2;
  localparam logic [2:0] MODE_TXRDY  = 3'd3;
  localparam logic [2:0] MODE_CLR_RX = 3'd4;
  localparam logic [2:0] MODE_CLR_TX = 3'd5;

  // Internal operation codes
  localparam logic [2:0] OP_LINE   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_TXRDY  = 3'd3;
  localparam logic [2:0] OP_CLR_RX = 3'd4;
  localparam logic [2:0] OP_CLR_TX = 3'd5;
  localparam logic [2:0] OP_BAD    = 3'd6;

  // Line status bits
  localparam logic [7:0] LS_OVERRUN = 8'h02;
  localparam logic [7:0] LS_PARITY  = 8'h04;
  localparam logic [7:0] LS_FRAME   = 8'h08;
  localparam logic [7:0] LS_FIFO    = 8'h80;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NA    = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Line error codes
  localparam logic [1:0] LERR_NONE    = 2'd0;
  localparam logic [1:0] LERR_PARITY  = 2'd1;
  localparam logic [1:0] LERR_FRAME   = 2'd2;
  localparam logic [1:0] LERR_OVERRUN = 2'd3;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_in;
    logic [7:0] line_status;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       data_out;
    logic             data_valid;
    logic [1:0]       line_error;
    logic             buffer_full_event;
    logic             data_received;
    logic             tx_active;
    logic [CNT_W-1:0] rx_count;
    logic [CNT_W-1:0] tx_count;
  } out_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       drop;
    logic [1:0] lerr;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/urb_front.sv
// ----------------------------------------------------------------------------
// urb_front
// Accepts input transactions and classifies them into queue commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module urb_front (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire urb_pkg::in_t  in_item,
  input  wire logic          q_full,
  output logic               push,
  output urb_pkg::cmd_t      cmd
);

  // Accept whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Mode decode, drop check and line error priority
  always_comb begin
    cmd.data = in_item.data_in;
    unique case (in_item.mode)
      urb_pkg::MODE_LINE:   cmd.op = urb_pkg::OP_LINE;
      urb_pkg::MODE_WRITE:  cmd.op = urb_pkg::OP_WRITE;
      urb_pkg::MODE_READ:   cmd.op = urb_pkg::OP_READ;
      urb_pkg::MODE_TXRDY:  cmd.op = urb_pkg::OP_TXRDY;
      urb_pkg::MODE_CLR_RX: cmd.op = urb_pkg::OP_CLR_RX;
      urb_pkg::MODE_CLR_TX: cmd.op = urb_pkg::OP_CLR_TX;
      default:              cmd.op = urb_pkg::OP_BAD;
    endcase

    // fifo error alone keeps the byte
    cmd.drop = |(in_item.line_status &
                 (urb_pkg::LS_PARITY | urb_pkg::LS_OVERRUN | urb_pkg::LS_FRAME));

    priority if ((in_item.line_status & urb_pkg::LS_PARITY) != '0) begin
      cmd.lerr = urb_pkg::LERR_PARITY;
    end else if ((in_item.line_status & (urb_pkg::LS_FRAME | urb_pkg::LS_FIFO)) != '0) begin
      cmd.lerr = urb_pkg::LERR_FRAME;
    end else if ((in_item.line_status & urb_pkg::LS_OVERRUN) != '0) begin
      cmd.lerr = urb_pkg::LERR_OVERRUN;
    end else begin
      cmd.lerr = urb_pkg::LERR_NONE;
    end
  end

endmodule

`default_nettype wire

### hdl/urb_queue.sv
// ----------------------------------------------------------------------------
// urb_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module urb_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire urb_pkg::cmd_t din,
  output logic               full,
  output logic               valid,
  input  wire logic          pop,
  output urb_pkg::cmd_t      dout
);

  urb_pkg::cmd_t             entries [urb_pkg::QDEPTH];
  logic [urb_pkg::QAW-1:0]   wr_ptr;
  logic [urb_pkg::QAW-1:0]   rd_ptr;
  logic [urb_pkg::QCW-1:0]   count;
  logic [urb_pkg::QAW-1:0]   wr_ptr_next;
  logic [urb_pkg::QAW-1:0]   rd_ptr_next;
  logic [urb_pkg::QCW-1:0]   count_next;

  assign full  = (count == urb_pkg::QCW'(urb_pkg::QDEPTH));
  assign valid = (count != '0);
  assign dout  = entries[rd_ptr];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == urb_pkg::QAW'(urb_pkg::QDEPTH - 1)) ? '0 :
                    wr_ptr + urb_pkg::QAW'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == urb_pkg::QAW'(urb_pkg::QDEPTH - 1)) ? '0 :
                    rd_ptr + urb_pkg::QAW'(1);
    end
    if (push && !pop) begin
      count_next = count + urb_pkg::QCW'(1);
    end else if (pop && !push) begin
      count_next = count - urb_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

### hdl/urb_back.sv
// ----------------------------------------------------------------------------
// urb_back
// Executes queued commands against the receive and transmit rings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module urb_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_valid,
  input  wire urb_pkg::cmd_t           cmd,
  output logic                         pop,
  input  wire logic                    cfg_we,
  input  wire logic [urb_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [urb_pkg::CFG_DW-1:0] cfg_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output urb_pkg::out_t                out_item
);

  // Ring storage
  logic [7:0] rx_mem [urb_pkg::RX_DEPTH];
  logic [7:0] tx_mem [urb_pkg::TX_DEPTH];
  logic [7:0] rx_rd;
  logic [7:0] tx_rd;

  // Ring state and configuration
  logic [urb_pkg::RX_AW-1:0] rx_head, rx_tail, rx_head_next, rx_tail_next;
  logic [urb_pkg::TX_AW-1:0] tx_head, tx_tail, tx_head_next, tx_tail_next;
  logic [urb_pkg::RX_CW-1:0] rx_fill, rx_fill_next, rx_eff, rx_eff_next;
  logic [urb_pkg::TX_CW-1:0] tx_fill, tx_fill_next, tx_eff, tx_eff_next;
  logic                      tx_irq, tx_irq_next;
  logic                      enabled, enabled_next;

  // Per-transaction strobes
  logic rx_we, tx_we, rx_re, tx_re;
  logic exec;

  // Output register
  urb_pkg::out_t res, out_res;
  logic          out_from_tx;
  logic          out_valid_next;

  // Size register decode
  logic [urb_pkg::RX_SZW-1:0] rx_req;
  logic [urb_pkg::TX_SZW-1:0] tx_req;
  logic [urb_pkg::RX_CW-1:0]  rx_size_eff;
  logic [urb_pkg::TX_CW-1:0]  tx_size_eff;

  // Wrapped pointer increments
  logic [urb_pkg::RX_AW-1:0] rx_head_inc, rx_tail_inc;
  logic [urb_pkg::TX_AW-1:0] tx_head_inc, tx_tail_inc;

  assign exec = q_valid && (!out_valid || !out_stall);
  assign pop  = exec;

  assign rx_head_inc = (urb_pkg::RX_CW'(rx_head) + urb_pkg::RX_CW'(1) == rx_eff) ? '0 :
                       rx_head + urb_pkg::RX_AW'(1);
  assign rx_tail_inc = (urb_pkg::RX_CW'(rx_tail) + urb_pkg::RX_CW'(1) == rx_eff) ? '0 :
                       rx_tail + urb_pkg::RX_AW'(1);
  assign tx_head_inc = (urb_pkg::TX_CW'(tx_head) + urb_pkg::TX_CW'(1) == tx_eff) ? '0 :
                       tx_head + urb_pkg::TX_AW'(1);
  assign tx_tail_inc = (urb_pkg::TX_CW'(tx_tail) + urb_pkg::TX_CW'(1) == tx_eff) ? '0 :
                       tx_tail + urb_pkg::TX_AW'(1);

  // Zero acts as one, anything above the depth acts as the depth
  assign rx_req = urb_pkg::RX_SZW'(cfg_data);
  assign tx_req = urb_pkg::TX_SZW'(cfg_data);
  assign rx_size_eff = (rx_req == '0) ? urb_pkg::RX_CW'(1) :
                       (rx_req > urb_pkg::RX_SZW'(urb_pkg::RX_DEPTH)) ?
                       urb_pkg::RX_CW'(urb_pkg::RX_DEPTH) : urb_pkg::RX_CW'(rx_req);
  assign tx_size_eff = (tx_req == '0) ? urb_pkg::TX_CW'(1) :
                       (tx_req > urb_pkg::TX_SZW'(urb_pkg::TX_DEPTH)) ?
                       urb_pkg::TX_CW'(urb_pkg::TX_DEPTH) : urb_pkg::TX_CW'(tx_req);

  // Command execution and configuration writes
  always_comb begin
    rx_head_next = rx_head;
    rx_tail_next = rx_tail;
    rx_fill_next = rx_fill;
    tx_head_next = tx_head;
    tx_tail_next = tx_tail;
    tx_fill_next = tx_fill;
    tx_irq_next  = tx_irq;
    enabled_next = enabled;
    rx_eff_next  = rx_eff;
    tx_eff_next  = tx_eff;
    rx_we = 1'b0;
    tx_we = 1'b0;
    rx_re = 1'b0;
    tx_re = 1'b0;
    res = '0;
    res.status = urb_pkg::ST_DONE;

    if (exec) begin
      unique case (cmd.op)
        urb_pkg::OP_CLR_RX: begin
          rx_head_next = '0;
          rx_tail_next = '0;
          rx_fill_next = '0;
        end
        urb_pkg::OP_CLR_TX: begin
          tx_head_next = '0;
          tx_tail_next = '0;
          tx_fill_next = '0;
        end
        urb_pkg::OP_LINE: begin
          if (!enabled) begin
            res.status = urb_pkg::ST_NA;
          end else begin
            res.line_error = cmd.lerr;
            if (cmd.drop) begin
              res.status = urb_pkg::ST_FULL;
            end else if (rx_fill >= rx_eff) begin
              res.status = urb_pkg::ST_FULL;
              res.buffer_full_event = 1'b1;
            end else begin
              rx_we = 1'b1;
              rx_head_next = rx_head_inc;
              rx_fill_next = rx_fill + urb_pkg::RX_CW'(1);
              res.data_received = 1'b1;
            end
          end
        end
        urb_pkg::OP_WRITE: begin
          if (!enabled) begin
            res.status = urb_pkg::ST_NA;
          end else if (tx_fill >= tx_eff) begin
            res.status = urb_pkg::ST_FULL;
            res.buffer_full_event = 1'b1;
          end else begin
            tx_we = 1'b1;
            tx_head_next = tx_head_inc;
            tx_fill_next = tx_fill + urb_pkg::TX_CW'(1);
            tx_irq_next  = 1'b1;
          end
        end
        urb_pkg::OP_READ: begin
          if (!enabled) begin
            res.status = urb_pkg::ST_NA;
          end else if (rx_fill == '0) begin
            res.status = urb_pkg::ST_EMPTY;
          end else begin
            rx_re = 1'b1;
            res.data_valid = 1'b1;
            rx_tail_next = rx_tail_inc;
            rx_fill_next = rx_fill - urb_pkg::RX_CW'(1);
          end
        end
        urb_pkg::OP_TXRDY: begin
          if (!enabled) begin
            res.status = urb_pkg::ST_NA;
          end else if (tx_fill == '0) begin
            res.status  = urb_pkg::ST_EMPTY;
            tx_irq_next = 1'b0;
          end else begin
            tx_re = 1'b1;
            res.data_valid = 1'b1;
            tx_tail_next = tx_tail_inc;
            tx_fill_next = tx_fill - urb_pkg::TX_CW'(1);
          end
        end
        default: begin
          res.status = urb_pkg::ST_NA;
        end
      endcase
    end

    res.tx_active = tx_irq_next;
    res.rx_count  = urb_pkg::CNT_W'(rx_fill_next);
    res.tx_count  = urb_pkg::CNT_W'(tx_fill_next);

    // Config writes must only arrive while idle; the block itself does not enforce it
    if (cfg_we) begin
      unique case (cfg_index)
        urb_pkg::REG_RX_SIZE: begin
          rx_eff_next  = rx_size_eff;
          rx_head_next = '0;
          rx_tail_next = '0;
          rx_fill_next = '0;
        end
        urb_pkg::REG_TX_SIZE: begin
          tx_eff_next  = tx_size_eff;
          tx_head_next = '0;
          tx_tail_next = '0;
          tx_fill_next = '0;
        end
        urb_pkg::REG_ENABLED: begin
          if (cfg_data[0] != enabled) begin
            rx_head_next = '0;
            rx_tail_next = '0;
            rx_fill_next = '0;
            tx_head_next = '0;
            tx_tail_next = '0;
            tx_fill_next = '0;
            tx_irq_next  = cfg_data[0];
          end
          enabled_next = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Output holds while stalled
  always_comb begin
    if (exec) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head   <= '0;
      rx_tail   <= '0;
      rx_fill   <= '0;
      tx_head   <= '0;
      tx_tail   <= '0;
      tx_fill   <= '0;
      tx_irq    <= 1'b0;
      enabled   <= 1'b0;
      rx_eff    <= urb_pkg::RX_CW'(urb_pkg::RX_EFF_RST);
      tx_eff    <= urb_pkg::TX_CW'(urb_pkg::TX_EFF_RST);
      out_valid <= 1'b0;
    end else begin
      rx_head   <= rx_head_next;
      rx_tail   <= rx_tail_next;
      rx_fill   <= rx_fill_next;
      tx_head   <= tx_head_next;
      tx_tail   <= tx_tail_next;
      tx_fill   <= tx_fill_next;
      tx_irq    <= tx_irq_next;
      enabled   <= enabled_next;
      rx_eff    <= rx_eff_next;
      tx_eff    <= tx_eff_next;
      out_valid <= out_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (exec) begin
      out_res     <= res;
      out_from_tx <= tx_re;
    end
  end

  // Ring memories, registered read
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_head] <= cmd.data;
    end
    if (rx_re) begin
      rx_rd <= rx_mem[rx_tail];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_head] <= cmd.data;
    end
    if (tx_re) begin
      tx_rd <= tx_mem[tx_tail];
    end
  end

  // Read data joins the registered result
  always_comb begin
    out_item = out_res;
    if (out_res.data_valid) begin
      out_item.data_out = out_from_tx ? tx_rd : rx_rd;
    end else begin
      out_item.data_out = 8'h00;
    end
  end

endmodule

`default_nettype wire

### hdl/uart_buffered_rx_tx_rings_unit.sv
// ----------------------------------------------------------------------------
// uart_buffered_rx_tx_rings_unit
// Receive and transmit byte rings between a UART line and a host.
//
// Input channel (in_valid/in_stall/in_item): one event per transaction -
// a line byte with its status, a host write, a host read, a transmitter
// ready event, or a clear of either ring. Output channel (out_valid/
// out_stall/out_item): exactly one result per event, in order.
// Config port (cfg_we/cfg_index/cfg_data): ring sizes and port enable;
// write only while no event is in flight.
// Order: an accepted event is written into the queue, then executed from
// the queue into the output register when the result is not held by
// out_stall; read data comes from the ring memory read port in step with
// the result register.
// Throughput: one event per cycle while out_stall is low; each event makes
// at most one access to one ring memory.
// A two-entry queue sits between the classifier and the executor; while
// out_stall is high the result holds, the queue fills and in_stall rises.
// Reset: both rings empty, sizes 256, port closed, transmit irq off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "uart_buffered_rx_tx_rings_unit_macros.svh"

module uart_buffered_rx_tx_rings_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire urb_pkg::in_t               in_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output urb_pkg::out_t                   out_item,
  input  wire logic                       cfg_we,
  input  wire logic [urb_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [urb_pkg::CFG_DW-1:0] cfg_data
);

  logic          q_full;
  logic          q_valid;
  logic          push;
  logic          pop;
  urb_pkg::cmd_t front_cmd;
  urb_pkg::cmd_t q_cmd;

  // Classifier
  urb_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  // Command queue
  urb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .full  (q_full),
    .valid (q_valid),
    .pop   (pop),
    .dout  (q_cmd)
  );

  // Ring executor
  urb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .cmd       (q_cmd),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Checks
  `URB_ASSERT_IMP(a_data_done, clk, rst, out_valid && out_item.data_valid,
                  out_item.status == urb_pkg::ST_DONE)
  `URB_ASSERT_IMP(a_full_status, clk, rst, out_valid && out_item.buffer_full_event,
                  out_item.status == urb_pkg::ST_FULL)
  `URB_ASSERT_IMP(a_recv_done, clk, rst, out_valid && out_item.data_received,
                  out_item.status == urb_pkg::ST_DONE && out_item.rx_count != '0)
  `URB_ASSERT_NXT(a_pop_result, clk, rst, pop, out_valid)

endmodule

`default_nettype wire
